// File: design/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, also checked while reset is applied
`define ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/vap_pkg.sv
// Shared types and constants of the vertex attribute packer.
// No dependencies; imported by every module of the block.
package vap_pkg;

    localparam int VAP_LANES       = 4;
    localparam int VAP_QUEUE_DEPTH = 2;

    // Attribute encoding codes
    localparam logic [3:0] KIND_NONE     = 4'd0;
    localparam logic [3:0] KIND_F32X1    = 4'd1;
    localparam logic [3:0] KIND_F32X2    = 4'd2;
    localparam logic [3:0] KIND_F32X3    = 4'd3;
    localparam logic [3:0] KIND_F32X4    = 4'd4;
    localparam logic [3:0] KIND_HALF2    = 4'd5;
    localparam logic [3:0] KIND_HALF4    = 4'd6;
    localparam logic [3:0] KIND_UNORM8   = 4'd7;
    localparam logic [3:0] KIND_BYTE4    = 4'd8;
    localparam logic [3:0] KIND_SNORM8   = 4'd9;
    localparam logic [3:0] KIND_SKIN_W   = 4'd10;
    localparam logic [3:0] KIND_SKIN_IDX = 4'd11;

    // Conversion class decided by the front end
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_F32,
        CLS_HALF,
        CLS_UNORM,
        CLS_SNORM,
        CLS_TRUNC
    } t_cls;

    // One classified item, components already in lane order
    typedef struct packed {
        t_cls                         cls;
        logic [VAP_LANES-1:0]         lane_en;
        logic [4:0]                   byte_count;
        logic [VAP_LANES-1:0][63:0]   comp;
        logic                         vend;
        logic                         bend;
    } t_item;

endpackage

// File: design/vap_front.sv
// Front end: accepts items, decodes the kind and orders the components.
// Depends on vap_pkg.
module vap_front import vap_pkg::*; (
    input  logic        i_start,
    input  logic        i_full,
    input  logic [3:0]  i_kind,
    input  logic [63:0] i_comp_a,
    input  logic [63:0] i_comp_b,
    input  logic [63:0] i_comp_c,
    input  logic [63:0] i_comp_d,
    input  logic        i_vertex_end_in,
    input  logic        i_buffer_end_in,
    output logic        o_push,
    output t_item       o_item
);

    assign o_push = i_start && !i_full;

    // Classify the kind
    always_comb begin
        o_item.comp       = {i_comp_d, i_comp_c, i_comp_b, i_comp_a};
        o_item.vend       = i_vertex_end_in;
        o_item.bend       = i_buffer_end_in;
        o_item.cls        = CLS_NONE;
        o_item.lane_en    = 4'b0000;
        o_item.byte_count = 5'd0;
        unique case (i_kind)
            KIND_F32X1: begin
                o_item.cls = CLS_F32; o_item.lane_en = 4'b0001; o_item.byte_count = 5'd4;
            end
            KIND_F32X2: begin
                o_item.cls = CLS_F32; o_item.lane_en = 4'b0011; o_item.byte_count = 5'd8;
            end
            KIND_F32X3: begin
                o_item.cls = CLS_F32; o_item.lane_en = 4'b0111; o_item.byte_count = 5'd12;
            end
            KIND_F32X4: begin
                o_item.cls = CLS_F32; o_item.lane_en = 4'b1111; o_item.byte_count = 5'd16;
            end
            KIND_HALF2: begin
                o_item.cls = CLS_HALF; o_item.lane_en = 4'b0011; o_item.byte_count = 5'd4;
            end
            KIND_HALF4: begin
                o_item.cls = CLS_HALF; o_item.lane_en = 4'b1111; o_item.byte_count = 5'd8;
            end
            KIND_UNORM8: begin
                o_item.cls = CLS_UNORM; o_item.lane_en = 4'b1111; o_item.byte_count = 5'd4;
            end
            KIND_BYTE4: begin
                o_item.cls = CLS_TRUNC; o_item.lane_en = 4'b1111; o_item.byte_count = 5'd4;
            end
            KIND_SNORM8: begin
                o_item.cls = CLS_SNORM; o_item.lane_en = 4'b1111; o_item.byte_count = 5'd4;
            end
            // skin data goes out in byte order 2,1,0,3
            KIND_SKIN_W: begin
                o_item.cls = CLS_UNORM; o_item.lane_en = 4'b1111; o_item.byte_count = 5'd4;
                o_item.comp = {i_comp_d, i_comp_a, i_comp_b, i_comp_c};
            end
            KIND_SKIN_IDX: begin
                o_item.cls = CLS_TRUNC; o_item.lane_en = 4'b1111; o_item.byte_count = 5'd4;
                o_item.comp = {i_comp_d, i_comp_a, i_comp_b, i_comp_c};
            end
            default: begin
                o_item.cls = CLS_NONE;
            end
        endcase
    end

endmodule

// File: design/vap_queue.sv
// Short queue of classified items between front and back ends.
// Depends on vap_pkg.
module vap_queue import vap_pkg::*; #(
    parameter int DEPTH = VAP_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty,
    output logic  o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: design/vap_back.sv
// Back end: two-stage conversion of four lanes and assembly of the packed bytes.
// Depends on vap_pkg.
module vap_back import vap_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    output logic [63:0] o_packed_low,
    output logic [63:0] o_packed_high,
    output logic [4:0]  o_byte_count,
    output logic        o_overflow_flag,
    output logic        o_vertex_end_out,
    output logic        o_buffer_end_out
);

    // Per-lane result of the first stage
    typedef struct packed {
        logic [31:0] res;
        logic        ovf;
        logic [53:0] q;
        logic [5:0]  s;
        logic        nan;
        logic        sat;
        logic        zero;
        logic        sgn;
    } t_lane;

    // Shift right with round to nearest, ties to even
    function automatic logic [63:0] rne_shift(input logic [63:0] m, input logic [6:0] s);
        logic [63:0] q, rem, half;
        begin
            q    = m >> s;
            rem  = m & ~({64{1'b1}} << s);
            half = 64'd1 << (s - 7'd1);
            if (s == 7'd0) begin
                q = m;
            end else if (s[6]) begin
                q = 64'd0;
            end else if (rem > half || (rem == half && q[0])) begin
                q = q + 64'd1;
            end
            return q;
        end
    endfunction

    // First stage: float32, half, truncated byte, and the scaled norm product
    function automatic t_lane lane_a(input logic [63:0] x, input t_cls cls, input logic en);
        t_lane       l;
        logic [10:0] ex, ts;
        logic [51:0] man;
        logic [52:0] m;
        logic        sgn;
        logic [31:0] f32;
        logic        f_ovf, h_ovf;
        logic [15:0] hf;
        logic [34:0] fbits;
        logic [16:0] hbits;
        logic [63:0] rr;
        logic [9:0]  fs;
        logic [10:0] hs;
        logic [60:0] p;
        logic [6:0]  d;
        logic [12:0] es, s13;
        logic [7:0]  v;
        begin
            ex    = x[62:52];
            man   = x[51:0];
            m     = {1'b1, man};
            sgn   = x[63];
            f_ovf = 1'b0;
            h_ovf = 1'b0;
            rr    = 64'd0;

            // float32
            if (ex == 11'h7FF) begin
                f32 = (man != 52'd0) ? {sgn, 8'hFF, man[51:29] | 23'h400000}
                                     : {sgn, 8'hFF, 23'd0};
            end else if (ex == 11'd0) begin
                f32 = {sgn, 31'd0};
            end else if (ex >= 11'd897) begin
                rr    = rne_shift({11'd0, m}, 7'd29);
                fbits = 35'({ex - 11'd897, 23'd0}) + rr[34:0];
                if (fbits >= 35'h7F800000) begin
                    f_ovf = 1'b1;
                    f32   = {sgn, 8'hFF, 23'd0};
                end else begin
                    f32 = {sgn, fbits[30:0]};
                end
            end else begin
                fs  = 10'd926 - 10'(ex);
                rr  = rne_shift({11'd0, m}, (fs >= 10'd64) ? 7'd64 : {1'b0, fs[5:0]});
                f32 = {sgn, rr[30:0]};
            end

            // half
            if (ex == 11'h7FF) begin
                hf = (man != 52'd0) ? 16'h7E00 : {sgn, 15'h7C00};
            end else if (ex == 11'd0) begin
                hf = {sgn, 15'd0};
            end else if (ex >= 11'd1039) begin
                h_ovf = 1'b1;
                hf    = {sgn, 15'h7C00};
            end else if (ex >= 11'd1009) begin
                rr    = rne_shift({11'd0, m}, 7'd42);
                hs    = ex - 11'd1009;
                hbits = 17'({hs[4:0], 10'd0}) + rr[16:0];
                if (hbits >= 17'h7C00) begin
                    h_ovf = 1'b1;
                    hf    = {sgn, 15'h7C00};
                end else begin
                    hf = {sgn, hbits[14:0]};
                end
            end else begin
                hs = 11'd1051 - ex;
                rr = rne_shift({11'd0, m}, (hs >= 11'd64) ? 7'd64 : {1'b0, hs[5:0]});
                hf = {sgn, rr[14:0]};
            end

            // truncated byte mod 256
            ts = 11'd1075 - ex;
            if (ex == 11'h7FF || ex == 11'd0 || ex >= 11'd1083) begin
                v = 8'd0;
            end else if (ex >= 11'd1075) begin
                ts = ex - 11'd1075;
                v  = 8'(m[7:0] << ts[2:0]);
            end else if (ts >= 11'd64) begin
                v = 8'd0;
            end else begin
                v = 8'(m >> ts[5:0]);
            end
            if (sgn) begin
                v = 8'(~v + 8'd1);
            end

            // scaled product rounded to double precision
            if (cls == CLS_UNORM) begin
                p = {m, 8'd0} - {8'd0, m};
            end else begin
                p = {1'b0, m, 7'd0} - {8'd0, m};
            end
            d   = p[60] ? 7'd8 : (p[59] ? 7'd7 : 7'd6);
            rr  = rne_shift({3'd0, p}, d);
            es  = {2'b00, ex} - 13'd1023;
            s13 = 13'd52 - es - {6'd0, d};

            l.q    = rr[53:0];
            l.s    = s13[5:0];
            l.nan  = (ex == 11'h7FF) && (man != 52'd0);
            l.sat  = (ex == 11'h7FF) || ($signed(es) >= 13'sd8);
            l.zero = (ex == 11'd0) || ($signed(es) < -13'sd12);
            l.sgn  = sgn;
            l.res  = 32'd0;
            l.ovf  = 1'b0;
            if (en) begin
                unique case (cls)
                    CLS_F32: begin
                        l.res = f32; l.ovf = f_ovf;
                    end
                    CLS_HALF: begin
                        l.res = {16'd0, hf}; l.ovf = h_ovf;
                    end
                    CLS_TRUNC: begin
                        l.res = {24'd0, v};
                    end
                    default: begin
                        l.res = 32'd0;
                    end
                endcase
            end
            return l;
        end
    endfunction

    // Second stage: final integer rounding and clamp of the norm bytes
    function automatic logic [7:0] lane_b(input t_lane l, input t_cls cls);
        logic [63:0] r;
        logic [6:0]  mag;
        logic [7:0]  b;
        begin
            r = rne_shift({10'd0, l.q}, {1'b0, l.s});
            if (l.sat) begin
                mag = 7'd127;
            end else if (l.zero) begin
                mag = 7'd0;
            end else if (r >= 64'd127) begin
                mag = 7'd127;
            end else begin
                mag = r[6:0];
            end
            if (cls == CLS_UNORM) begin
                if (l.sgn || l.nan || l.zero) begin
                    b = 8'd0;
                end else if (l.sat || r >= 64'd255) begin
                    b = 8'hFF;
                end else begin
                    b = r[7:0];
                end
            end else if (l.nan) begin
                b = 8'h81;
            end else if (l.sgn) begin
                b = 8'(~{1'b0, mag} + 8'd1);
            end else begin
                b = {1'b0, mag};
            end
            return b;
        end
    endfunction

    t_lane       r_a_lane [VAP_LANES];
    t_cls        r_a_cls;
    logic [4:0]  r_a_count;
    logic        r_a_vend, r_a_bend, r_a_valid;

    logic        r_valid;
    logic [63:0] r_lo, r_hi;
    logic [4:0]  r_count;
    logic        r_ovf, r_vend, r_bend;

    logic [63:0] n_lo, n_hi;
    logic        n_ovf;
    logic [7:0]  b [VAP_LANES];

    // The back end never stalls: take an item whenever one waits
    assign o_pop = i_valid;

    // Valid flags of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_valid   <= r_a_valid;
        end
    end

    // Stage one payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < VAP_LANES; i++) begin
            r_a_lane[i] <= lane_a(i_item.comp[i], i_item.cls, i_item.lane_en[i]);
        end
        r_a_cls   <= i_item.cls;
        r_a_count <= i_item.byte_count;
        r_a_vend  <= i_item.vend;
        r_a_bend  <= i_item.bend;
    end

    // Assemble packed words
    always_comb begin
        n_lo  = 64'd0;
        n_hi  = 64'd0;
        n_ovf = 1'b0;
        for (int i = 0; i < VAP_LANES; i++) begin
            b[i]  = (r_a_cls == CLS_TRUNC) ? r_a_lane[i].res[7:0]
                                           : lane_b(r_a_lane[i], r_a_cls);
            n_ovf = n_ovf | r_a_lane[i].ovf;
        end
        unique case (r_a_cls)
            CLS_F32: begin
                n_lo = {r_a_lane[1].res, r_a_lane[0].res};
                n_hi = {r_a_lane[3].res, r_a_lane[2].res};
            end
            CLS_HALF: begin
                n_lo = {r_a_lane[3].res[15:0], r_a_lane[2].res[15:0],
                        r_a_lane[1].res[15:0], r_a_lane[0].res[15:0]};
            end
            CLS_UNORM, CLS_SNORM, CLS_TRUNC: begin
                n_lo = {32'd0, b[3], b[2], b[1], b[0]};
            end
            default: begin
                n_lo = 64'd0;
            end
        endcase
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_ovf   <= n_ovf;
        r_count <= r_a_count;
        r_vend  <= r_a_vend;
        r_bend  <= r_a_bend;
    end

    assign o_valid          = r_valid;
    assign o_packed_low     = r_lo;
    assign o_packed_high    = r_hi;
    assign o_byte_count     = r_count;
    assign o_overflow_flag  = r_ovf;
    assign o_vertex_end_out = r_vend;
    assign o_buffer_end_out = r_bend;

endmodule

// File: design/vertex_attribute_packer.sv
// Vertex attribute packer: converts one attribute to its packed bytes.
// Instantiates vap_front, vap_queue and vap_back; depends on vap_pkg.
//
// Input: drive the kind, four binary64 components and the end markers, and
// raise start; the item is taken at an edge where start is high and busy low.
// Output: one result per item, shown for exactly one cycle with o_valid high:
// packed bytes, byte count, overflow flag and the copied end markers.
// The accepted item is written to the queue, then to the stage-one and result registers.
// Throughput: one item per cycle. The front end writes a two-entry queue and
// the back end drains it every cycle through a two-stage conversion pipeline
// (rounding to float32/half and scaled products, then the final byte rounding).
// busy rises only when the queue is full, which the back end never lets happen.
// The receiver cannot stall; results are never held back.
// Reset (synchronous, active low) empties the queue and drops items in flight.
module vertex_attribute_packer import vap_pkg::*; #(
    parameter int QUEUE_DEPTH = VAP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_kind,
    input  logic [63:0] i_comp_a,
    input  logic [63:0] i_comp_b,
    input  logic [63:0] i_comp_c,
    input  logic [63:0] i_comp_d,
    input  logic        i_vertex_end_in,
    input  logic        i_buffer_end_in,
    output logic        o_valid,
    output logic [63:0] o_packed_low,
    output logic [63:0] o_packed_high,
    output logic [4:0]  o_byte_count,
    output logic        o_overflow_flag,
    output logic        o_vertex_end_out,
    output logic        o_buffer_end_out
);

    t_item push_item, pop_item;
    logic  push, pop, empty, full;

    assign busy = full;

    vap_front u_front (
        .i_start         (start),
        .i_full          (full),
        .i_kind          (i_kind),
        .i_comp_a        (i_comp_a),
        .i_comp_b        (i_comp_b),
        .i_comp_c        (i_comp_c),
        .i_comp_d        (i_comp_d),
        .i_vertex_end_in (i_vertex_end_in),
        .i_buffer_end_in (i_buffer_end_in),
        .o_push          (push),
        .o_item          (push_item)
    );

    vap_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_empty (empty),
        .o_full  (full)
    );

    vap_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (!empty),
        .i_item           (pop_item),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_packed_low     (o_packed_low),
        .o_packed_high    (o_packed_high),
        .o_byte_count     (o_byte_count),
        .o_overflow_flag  (o_overflow_flag),
        .o_vertex_end_out (o_vertex_end_out),
        .o_buffer_end_out (o_buffer_end_out)
    );

endmodule

// File: design/vap_checker.sv
// Port-level checks of the vertex attribute packer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module vap_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic [63:0] o_packed_low,
    input logic [63:0] o_packed_high,
    input logic [4:0]  o_byte_count,
    input logic        o_overflow_flag
);

    // Byte count never exceeds the sixteen-byte payload
    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, o_valid, o_byte_count <= 5'd16)

    // An empty result carries no bytes and no flag
    `ASSERT_IMPL(a_empty_clean, i_clk, i_rst_n, o_valid && o_byte_count == 5'd0, o_packed_low == 64'd0 && o_packed_high == 64'd0 && !o_overflow_flag)

    // Results of eight bytes or fewer leave the high word clear
    `ASSERT_IMPL(a_high_clear, i_clk, i_rst_n, o_valid && o_byte_count <= 5'd8, o_packed_high == 64'd0)

    // Reset drops any result in flight
    `ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_valid)

endmodule

bind vertex_attribute_packer vap_checker u_vap_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .o_packed_low    (o_packed_low),
    .o_packed_high   (o_packed_high),
    .o_byte_count    (o_byte_count),
    .o_overflow_flag (o_overflow_flag)
);
